### hw/rtl/ptq_pkg.sv
`default_nettype none
package ptq_pkg;
    localparam int unsigned CapacityDef = 16;
    localparam int unsigned MaxFiresDef = 63;
    localparam int unsigned IdBitsDef   = 32;

    localparam logic [2:0] OP_ADD     = 3'd0;
    localparam logic [2:0] OP_CANCEL  = 3'd1;
    localparam logic [2:0] OP_TIMEOUT = 3'd2;
    localparam logic [2:0] OP_EXIST   = 3'd3;
    localparam logic [2:0] OP_CLEAR   = 3'd4;

    localparam logic [2:0] K_ADD   = 3'd0;
    localparam logic [2:0] K_CANC  = 3'd1;
    localparam logic [2:0] K_EXIST = 3'd2;
    localparam logic [2:0] K_CLEAR = 3'd3;
    localparam logic [2:0] K_FIRED = 3'd4;
    localparam logic [2:0] K_DONE  = 3'd5;

    typedef struct packed {
        logic [2:0]  operation;
        logic [63:0] expire_at;
        logic [31:0] period;
        logic [31:0] query_id;
        logic [63:0] current_time;
    } t_req;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] result_id;
        logic [31:0] fired_period;
        logic        ok;
        logic [5:0]  fire_count;
        logic        more_pending;
        logic        last;
    } t_rsp;
endpackage
`default_nettype wire

### hw/rtl/ptq_if.sv
`default_nettype none
interface ptq_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

### hw/rtl/periodic_timer_queue_top.sv
`default_nettype none
// Add, cancel and exist each scan the whole slot table before their one result;
// clear empties the table without a scan. A timeout rescans the table after each
// fired result; a stalled result holds back the next one until it is taken.
// One request executes at a time, set by the one-slot-per-cycle table scan.
// Synchronous active-low reset empties the table and zeroes the id counter.
module periodic_timer_queue_top #(
    parameter int unsigned CAPACITY  = ptq_pkg::CapacityDef,
    parameter int unsigned MAX_FIRES = ptq_pkg::MaxFiresDef,
    parameter int unsigned ID_BITS   = ptq_pkg::IdBitsDef
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    ptq_if.sink      i_req,
    ptq_if.source    o_rsp
);
    import ptq_pkg::*;
    logic q_valid, q_ready;
    t_req q_req;

    ptq_front u_front (
        .i_clk, .i_rst_n,
        .i_valid(i_req.valid), .o_ready(i_req.ready), .i_req(i_req.payload),
        .o_valid(q_valid), .i_ready(q_ready), .o_req(q_req)
    );

    ptq_back #(.CAPACITY(CAPACITY), .MAX_FIRES(MAX_FIRES), .ID_BITS(ID_BITS)) u_back (
        .i_clk, .i_rst_n,
        .i_valid(q_valid), .o_ready(q_ready), .i_req(q_req),
        .o_valid(o_rsp.valid), .i_ready(o_rsp.ready), .o_rsp(o_rsp.payload)
    );
endmodule
`default_nettype wire

### hw/rtl/ptq_front.sv
`default_nettype none
// Accepts requests, drops unused opcodes, and holds a two-entry queue.
module ptq_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire ptq_pkg::t_req   i_req,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output ptq_pkg::t_req        o_req
);
    import ptq_pkg::*;
    t_req       r_q [2];
    logic [1:0] r_cnt, n_cnt;
    logic       r_wp, r_rp;
    logic       keep, deq;

    assign o_ready = (r_cnt != 2'd2);
    assign keep = (i_req.operation <= OP_CLEAR);
    assign deq  = o_valid && i_ready;
    assign o_valid = (r_cnt != 2'd0);
    assign o_req = r_q[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (i_valid && o_ready && keep) n_cnt = n_cnt + 2'd1;
        if (deq) n_cnt = n_cnt - 2'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (i_valid && o_ready && keep) begin
                r_q[r_wp] <= i_req;
                r_wp <= ~r_wp;
            end
            if (deq) r_rp <= ~r_rp;
        end
    end
endmodule
`default_nettype wire

### hw/rtl/ptq_back.sv
`default_nettype none
// Executes one request at a time by scanning the slot table one slot per cycle.
module ptq_back #(
    parameter int unsigned CAPACITY  = ptq_pkg::CapacityDef,
    parameter int unsigned MAX_FIRES = ptq_pkg::MaxFiresDef,
    parameter int unsigned ID_BITS   = ptq_pkg::IdBitsDef
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire ptq_pkg::t_req i_req,
    output logic               o_valid,
    input  wire logic          i_ready,
    output ptq_pkg::t_rsp      o_rsp
);
    import ptq_pkg::*;
    localparam int unsigned SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_FIRE, S_OUT} t_state;

    logic [CAPACITY-1:0] r_valid;
    logic [ID_BITS-1:0]  r_id  [CAPACITY];
    logic [63:0]         r_exp [CAPACITY];
    logic [31:0]         r_per [CAPACITY];
    logic [ID_BITS-1:0]  r_ctr;

    t_state        r_st;
    t_req          r_req;
    logic [SW-1:0] r_idx;
    logic [SW-1:0] r_hit, r_free;
    logic          r_found, r_hasfree;
    logic [5:0]    r_n;
    t_rsp          r_out, n_out;
    logic          r_ovalid;

    logic [SW-1:0] idx;
    logic [ID_BITS-1:0] nid;
    logic          due, better, fire;

    assign idx = r_idx;
    assign o_ready = (r_st == S_IDLE) && !r_ovalid;
    assign o_valid = r_ovalid;
    assign o_rsp = r_out;

    always_comb begin
        nid = r_ctr + 1'b1;
        if (nid == '0) nid = {{(ID_BITS-1){1'b0}}, 1'b1};
    end

    assign due = r_valid[idx] && (r_exp[idx] <= r_req.current_time);
    assign better = !r_found || (r_exp[idx] < r_exp[r_hit]) ||
        ((r_exp[idx] == r_exp[r_hit]) && (r_id[idx] < r_id[r_hit]));
    assign fire = (r_req.operation == OP_TIMEOUT) && r_found && (r_n < 6'(MAX_FIRES));

    always_comb begin
        n_out = '0;
        n_out.last = 1'b1;
        case (r_req.operation)
            OP_ADD: begin
                if (!r_found && r_hasfree) n_out.result_id = 32'(r_ctr);
            end
            OP_CANCEL: begin
                n_out.kind = K_CANC;
                n_out.ok = r_found;
            end
            OP_EXIST: begin
                n_out.kind = K_EXIST;
                n_out.ok = r_found;
            end
            OP_TIMEOUT: begin
                if (fire) begin
                    n_out.kind = K_FIRED;
                    n_out.last = 1'b0;
                    n_out.result_id = 32'(r_id[r_hit]);
                    n_out.fired_period = r_per[r_hit];
                end else begin
                    n_out.kind = K_DONE;
                    n_out.fire_count = r_n;
                    n_out.more_pending = r_found;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_valid <= '0;
            r_ctr <= '0;
            r_ovalid <= 1'b0;
            r_n <= '0;
            r_idx <= '0;
            r_found <= 1'b0;
            r_hasfree <= 1'b0;
        end else begin
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            case (r_st)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_req <= i_req;
                        r_idx <= '0;
                        r_found <= 1'b0;
                        r_hasfree <= 1'b0;
                        r_n <= '0;
                        if (i_req.operation == OP_ADD) r_ctr <= nid;
                        if (i_req.operation == OP_CLEAR) begin
                            r_valid <= '0;
                            r_out <= '{kind: K_CLEAR, last: 1'b1, default: '0};
                            r_ovalid <= 1'b1;
                        end else begin
                            r_st <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    case (r_req.operation)
                        OP_TIMEOUT: begin
                            if (due && better) begin
                                r_found <= 1'b1;
                                r_hit <= idx;
                            end
                        end
                        OP_ADD: begin
                            if (!r_valid[idx] && !r_hasfree) begin
                                r_hasfree <= 1'b1;
                                r_free <= idx;
                            end
                            if (r_valid[idx] && r_id[idx] == r_ctr) r_found <= 1'b1;
                        end
                        default: begin
                            if (r_valid[idx] && !r_found &&
                                64'(r_id[idx]) == 64'(r_req.query_id)) begin
                                r_found <= 1'b1;
                                r_hit <= idx;
                            end
                        end
                    endcase
                    if (r_idx == SW'(CAPACITY - 1)) r_st <= S_FIRE;
                    else r_idx <= r_idx + 1'b1;
                end
                S_FIRE: begin
                    if (!r_ovalid) begin
                        r_out <= n_out;
                        r_ovalid <= 1'b1;
                        r_st <= fire ? S_SCAN : S_IDLE;
                        case (r_req.operation)
                            OP_ADD: begin
                                if (!r_found && r_hasfree) begin
                                    r_valid[r_free] <= 1'b1;
                                    r_id[r_free] <= r_ctr;
                                    r_exp[r_free] <= r_req.expire_at;
                                    r_per[r_free] <= r_req.period;
                                end
                            end
                            OP_CANCEL: begin
                                if (r_found) r_valid[r_hit] <= 1'b0;
                            end
                            OP_TIMEOUT: begin
                                if (fire) begin
                                    if (r_per[r_hit] != '0)
                                        r_exp[r_hit] <= r_exp[r_hit] + 64'(r_per[r_hit]);
                                    else
                                        r_valid[r_hit] <= 1'b0;
                                    r_n <= r_n + 6'd1;
                                    r_idx <= '0;
                                    r_found <= 1'b0;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
